// ----- sv/rthv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the hash step for the route table header validator.
// Used by every module of the block; depends on nothing.
package rthv_pkg;

	localparam int CHECKSUM_POS = 40;
	localparam int WORD_COUNT   = CHECKSUM_POS / 4;
	localparam int SUM_BYTES    = 8;
	localparam int IN_DATA_W    = 8;
	localparam int OUT_DATA_W   = 232;
	localparam int CFG_IDX_W    = 3;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	// header magic, byte 0 in lane 0
	localparam logic [3:0][7:0] MAGIC = {8'h54, 8'h52, 8'h4C, 8'h53};

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_TRUNC    = 4'd1,
		ST_MAGIC    = 4'd2,
		ST_VERSION  = 4'd3,
		ST_HEADER   = 4'd4,
		ST_COUNT    = 4'd5,
		ST_RANGE    = 4'd6,
		ST_OVERLAP  = 4'd7,
		ST_CHECKSUM = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROUTE_COUNT  = 3'd0,
		CFG_VERSION      = 3'd1,
		CFG_ENDIAN       = 3'd2,
		CFG_HEADER_BYTES = 3'd3,
		CFG_ENTRY_BYTES  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] expected_route_count;
		logic [31:0] expected_version;
		logic [31:0] endian_marker;
		logic [31:0] header_bytes;
		logic [15:0] entry_bytes;
	} cfg_t;

	typedef logic [WORD_COUNT-1:0][3:0][7:0] words_t;

	// snapshot of one finished artifact
	typedef struct packed {
		words_t      words;
		logic [63:0] stored_sum;
		logic [63:0] hash;
		logic        magic_good;
	} rec_t;

	// failed checks, one flag each; count flag lacks the product compare
	typedef struct packed {
		logic trunc;
		logic magic;
		logic version;
		logic header;
		logic count;
		logic range;
		logic overlap;
		logic csum;
	} chk_t;

	// FNV-1a step; prime is 2^40 + 0x1b3, done as shift-add
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ----- sv/route_table_header_validator.sv -----
`timescale 1ns / 1ps
// Route table header validator: byte-stream artifact check, one status per artifact.
// Holds the configuration registers and ties front end, queue and back end; uses rthv_pkg.
//
// Usage:
//   Artifact bytes arrive on s_tdata in file order, one per accepted item; s_tlast marks
//   the final byte. Each final byte yields one result item on m_tdata: status, masked
//   FNV-1a hash, the header summary words and the saturated artifact length.
//   Bytes are taken at one per cycle. The front end is ready whenever the two-entry
//   snapshot queue has room, so it keeps running while the receiver stalls until four
//   finished artifacts wait (output register, check stage, two queue entries); only
//   then s_tready drops.
//   After the final byte is accepted, the artifact's snapshot passes through the queue, the
//   check stage (count product and range flags) and the output register.
//   Results for back-to-back artifacts leave at one per cycle while m_tready stays high.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no artifact is in
//   flight; unknown indexes are ignored.
//   Reset clears the stream state (hash basis, empty header, length zero), empties the
//   queue and pipeline and loads the register defaults.
module route_table_header_validator #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rthv_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] status, [67:4] computed_checksum, [99:68] routes,
	// [131:100] route_base, [163:132] strtab_base,
	// [195:164] strtab_len, [227:196] artifact_length, [231:228] zero
	output logic [rthv_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [rthv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import rthv_pkg::*;

	cfg_t                    cfg_q;
	logic                    push, q_full, q_valid, q_pop;
	rec_t                    f_rec, q_rec;
	logic [LENGTH_WIDTH-1:0] f_len, q_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_route_count <= 32'd0;
			cfg_q.expected_version     <= 32'd1;
			cfg_q.endian_marker        <= 32'd0;
			cfg_q.header_bytes         <= 32'd48;
			cfg_q.entry_bytes          <= 16'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROUTE_COUNT:  cfg_q.expected_route_count <= cfg_data;
				CFG_VERSION:      cfg_q.expected_version     <= cfg_data;
				CFG_ENDIAN:       cfg_q.endian_marker        <= cfg_data;
				CFG_HEADER_BYTES: cfg_q.header_bytes         <= cfg_data;
				CFG_ENTRY_BYTES:  cfg_q.entry_bytes          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rthv_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.rec      (f_rec),
		.len      (f_len)
	);

	rthv_queue #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rec_in  (f_rec),
		.len_in  (f_len),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rec_out (q_rec),
		.len_out (q_len)
	);

	rthv_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_rec    (q_rec),
		.q_len    (q_len),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- sv/rthv_front.sv -----
`timescale 1ns / 1ps
// Front end: takes artifact bytes, captures header words and stored checksum,
// runs the masked hash and hands a snapshot to the queue on the last byte. Uses rthv_pkg.
module rthv_front #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // [7:0] data_byte
	input  logic                      s_tlast,
	input  logic                      q_full,
	output logic                      push,
	output rthv_pkg::rec_t            rec,
	output logic [LENGTH_WIDTH-1:0]   len
);
	import rthv_pkg::*;

	localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

	logic [LENGTH_WIDTH-1:0] pos_q, len_d;
	logic [63:0]             hash_q, hash_d;
	logic                    magic_q, magic_d;
	words_t                  words_q, words_d;
	logic [7:0][7:0]         sum_q, sum_d;
	logic [7:0]              hb;
	logic                    accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && s_tlast;

	always_comb begin
		words_d = words_q;
		sum_d   = sum_q;
		magic_d = magic_q;
		hb      = s_tdata;
		if (pos_q < LENGTH_WIDTH'(4) && s_tdata != MAGIC[pos_q[1:0]])
			magic_d = 1'b0;
		if (pos_q < LENGTH_WIDTH'(CHECKSUM_POS)) begin
			words_d[pos_q[5:2]][pos_q[1:0]] = s_tdata;
		end else if (pos_q < LENGTH_WIDTH'(CHECKSUM_POS + SUM_BYTES)) begin
			// checksum field starts on an 8-byte boundary
			sum_d[pos_q[2:0]] = s_tdata;
			hb = 8'd0;
		end
		hash_d = fnv_step(hash_q, hb);
		len_d  = (pos_q != LEN_MAX) ? pos_q + 1'b1 : LEN_MAX;
	end

	assign rec = '{words: words_d, stored_sum: sum_d, hash: hash_d, magic_good: magic_d};
	assign len = len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hash_q  <= FNV_BASIS;
			magic_q <= 1'b1;
			words_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q   <= '0;
				hash_q  <= FNV_BASIS;
				magic_q <= 1'b1;
				words_q <= '0;
				sum_q   <= '0;
			end else begin
				pos_q   <= len_d;
				hash_q  <= hash_d;
				magic_q <= magic_d;
				words_q <= words_d;
				sum_q   <= sum_d;
			end
		end
	end

endmodule

// ----- sv/rthv_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of finished artifact snapshots between front and back end.
// Uses rthv_pkg.
module rthv_queue #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  rthv_pkg::rec_t          rec_in,
	input  logic [LENGTH_WIDTH-1:0] len_in,
	output logic                    full,
	input  logic                    pop,
	output logic                    valid,
	output rthv_pkg::rec_t          rec_out,
	output logic [LENGTH_WIDTH-1:0] len_out
);
	import rthv_pkg::*;

	rec_t                    ent_rec_q [2];
	logic [LENGTH_WIDTH-1:0] ent_len_q [2];
	logic                    wr_ptr_q, rd_ptr_q;
	logic [1:0]              cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign rec_out = ent_rec_q[rd_ptr_q];
	assign len_out = ent_len_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_rec_q[wr_ptr_q] <= rec_in;
			ent_len_q[wr_ptr_q] <= len_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) (push && !pop) |=> valid)
		else $error("pushed item lost");

endmodule

// ----- sv/rthv_back.sv -----
`timescale 1ns / 1ps
// Back end: runs the header checks on a queued snapshot in two stages
// (flags and count product, then status priority) into the output register. Uses rthv_pkg.
module rthv_back #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rthv_pkg::cfg_t          cfg,
	input  logic                    q_valid,
	input  rthv_pkg::rec_t          q_rec,
	input  logic [LENGTH_WIDTH-1:0] q_len,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [3:0] status, [67:4] computed_checksum, [99:68] routes,
	// [131:100] route_base, [163:132] strtab_base,
	// [195:164] strtab_len, [227:196] artifact_length, [231:228] zero
	output logic [rthv_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rthv_pkg::*;

	localparam int CW = ((LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32) + 1;
	localparam int EW = LENGTH_WIDTH + 32;

	function automatic logic span_ok(input logic [CW-1:0] l, input logic [CW-1:0] off,
		input logic [CW-1:0] size);
		return (off <= l) && (size <= l - off);
	endfunction

	logic [31:0]   w [WORD_COUNT];
	logic [CW-1:0] lenx;
	logic [EW-1:0] lenw;
	logic [31:0]   len_sat;
	logic [47:0]   prod_full;
	chk_t          chk_d;

	logic          valid_s1;
	chk_t          chk_s1;
	logic [31:0]   prod_s1, w7_s1, rc_s1, rto_s1, sto_s1, sts_s1, len_s1;
	logic [63:0]   hash_s1;
	logic          adv_s1, ready_s1, out_ready;
	status_t       status_d;

	always_comb begin
		for (int i = 0; i < WORD_COUNT; i++)
			w[i] = q_rec.words[i];
	end

	assign lenx      = CW'(q_len);
	assign lenw      = EW'(q_len);
	assign len_sat   = (|lenw[EW-1:32]) ? 32'hFFFF_FFFF : lenw[31:0];
	assign prod_full = w[4] * cfg.entry_bytes;

	always_comb begin
		chk_d.trunc   = lenx < CW'(cfg.header_bytes);
		chk_d.magic   = !q_rec.magic_good || lenx < CW'(4);
		chk_d.version = w[1] != cfg.expected_version;
		chk_d.header  = w[2] != cfg.endian_marker || w[3] != cfg.header_bytes;
		chk_d.count   = w[4] != cfg.expected_route_count || w[5] != cfg.expected_route_count;
		chk_d.range   = !span_ok(lenx, CW'(w[6]), CW'(w[7])) ||
		                !span_ok(lenx, CW'(w[8]), CW'(w[9]));
		chk_d.overlap = ({1'b0, w[6]} + {1'b0, w[7]}) > {1'b0, w[8]};
		chk_d.csum    = q_rec.hash != q_rec.stored_sum;
	end

	assign out_ready = !m_tvalid || m_tready;
	assign adv_s1    = valid_s1 && out_ready;
	assign ready_s1  = !valid_s1 || adv_s1;
	assign q_pop     = q_valid && ready_s1;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			chk_s1  <= chk_d;
			prod_s1 <= prod_full[31:0];
			w7_s1   <= w[7];
			hash_s1 <= q_rec.hash;
			rc_s1   <= w[4];
			rto_s1  <= w[6];
			sto_s1  <= w[8];
			sts_s1  <= w[9];
			len_s1  <= len_sat;
		end
	end

	always_comb begin
		priority if (chk_s1.trunc)                       status_d = ST_TRUNC;
		else if (chk_s1.magic)                           status_d = ST_MAGIC;
		else if (chk_s1.version)                         status_d = ST_VERSION;
		else if (chk_s1.header)                          status_d = ST_HEADER;
		else if (chk_s1.count || w7_s1 != prod_s1)       status_d = ST_COUNT;
		else if (chk_s1.range)                           status_d = ST_RANGE;
		else if (chk_s1.overlap)                         status_d = ST_OVERLAP;
		else if (chk_s1.csum)                            status_d = ST_CHECKSUM;
		else                                             status_d = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			m_tdata <= {4'd0, len_s1, sts_s1, sto_s1, rto_s1, rc_s1, hash_s1, status_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= q_pop;
			if (out_ready)
				m_tvalid <= valid_s1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> m_tdata[3:0] <= 4'(ST_CHECKSUM))
		else $error("status code out of range");
	assert property (@(posedge clk) disable iff (!arst_n) (valid_s1 && !out_ready) |=> valid_s1)
		else $error("stage 1 item dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n) (valid_s1 && !out_ready) |-> !q_pop)
		else $error("queue popped into a stalled stage");

endmodule

// ----- tb/route_table_header_validator_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for route_table_header_validator: streams whole artifacts byte by byte,
// predicts each status and header summary in a small tracker class and checks every result.
// Depends on rthv_pkg and the route_table_header_validator RTL.

import rthv_pkg::*;

localparam logic [63:0] HASH_SEED  = 64'hcbf29ce484222325;
localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
localparam logic [31:0] TAG_WORD   = 32'h54524C53; // tag bytes 53 4C 52 54, little-endian
localparam int          SUM_START  = 40;
localparam int          SUM_END    = 48;

typedef struct {
	status_t     status;
	logic [63:0] hash;
	logic [31:0] routes;
	logic [31:0] route_off;
	logic [31:0] str_off;
	logic [31:0] str_size;
	logic [31:0] length;
} art_summary_t;

typedef enum {ART_GOOD, ART_BAD_WORD, ART_OVERLAP, ART_BAD_BYTE, ART_TRUNC, ART_NOISE} art_kind_t;

function automatic logic [63:0] fnv1a_mix(input logic [63:0] h, input logic [7:0] b);
	return (h ^ {56'd0, b}) * HASH_PRIME;
endfunction

class artifact_tracker;
	logic [31:0] want_routes;
	logic [31:0] want_version;
	logic [31:0] want_marker;
	logic [31:0] want_hdr;
	logic [15:0] entry_size;

	logic [31:0] pos;
	logic [63:0] hash;
	bit          tag_ok;
	logic [31:0] words [WORD_COUNT];
	logic [63:0] stored;

	art_summary_t summaries_due [$];
	int errors;

	function void clear_stream();
		pos = 0;
		hash = HASH_SEED;
		tag_ok = 1;
		stored = 0;
		foreach (words[i])
			words[i] = 0;
	endfunction

	function void restart();
		want_routes = 0;
		want_version = 1;
		want_marker = 0;
		want_hdr = 48;
		entry_size = 32;
		errors = 0;
		summaries_due.delete();
		clear_stream();
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		case (idx)
			CFG_ROUTE_COUNT: want_routes = v;
			CFG_VERSION: want_version = v;
			CFG_ENDIAN: want_marker = v;
			CFG_HEADER_BYTES: want_hdr = v;
			CFG_ENTRY_BYTES: entry_size = v[15:0];
			default: ;
		endcase
	endfunction

	function bit span_fits(logic [31:0] len, logic [31:0] off, logic [31:0] size);
		return off <= len && size <= len - off;
	endfunction

	// one accepted item; a final byte queues the expected summary
	function void take_byte(logic [7:0] b, bit last);
		logic [7:0]  hb;
		logic [31:0] len;
		logic [31:0] product;
		logic [31:0] tag_word;
		status_t     st;
		art_summary_t s;
		hb = b;
		tag_word = TAG_WORD;
		if (pos < 4 && b != tag_word[{pos[1:0], 3'b000} +: 8])
			tag_ok = 0;
		if (pos < SUM_START) begin
			words[pos[5:2]][{pos[1:0], 3'b000} +: 8] = b;
		end else if (pos < SUM_END) begin
			stored[{pos[2:0], 3'b000} +: 8] = b;
			hb = 8'h00;
		end
		hash = fnv1a_mix(hash, hb);
		len = (pos != 32'hFFFFFFFF) ? pos + 1 : pos;
		pos = len;
		if (!last)
			return;
		product = words[4] * {16'd0, entry_size};
		if (len < want_hdr)
			st = ST_TRUNC;
		else if (!tag_ok || len < 4)
			st = ST_MAGIC;
		else if (words[1] != want_version)
			st = ST_VERSION;
		else if (words[2] != want_marker || words[3] != want_hdr)
			st = ST_HEADER;
		else if (words[4] != want_routes || words[5] != want_routes || words[7] != product)
			st = ST_COUNT;
		else if (!span_fits(len, words[6], words[7]) || !span_fits(len, words[8], words[9]))
			st = ST_RANGE;
		else if ({32'd0, words[6]} + {32'd0, words[7]} > {32'd0, words[8]})
			st = ST_OVERLAP;
		else if (hash != stored)
			st = ST_CHECKSUM;
		else
			st = ST_OK;
		s.status = st;
		s.hash = hash;
		s.routes = words[4];
		s.route_off = words[6];
		s.str_off = words[8];
		s.str_size = words[9];
		s.length = len;
		summaries_due.push_back(s);
		clear_stream();
	endfunction

	function void match(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endfunction

	function void check_summary(logic [OUT_DATA_W-1:0] d);
		art_summary_t e;
		if (summaries_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %h", $time, d);
			return;
		end
		e = summaries_due.pop_front();
		match("status", e.status, d[3:0]);
		match("computed_checksum", e.hash, d[67:4]);
		match("routes", e.routes, d[99:68]);
		match("route_base", e.route_off, d[131:100]);
		match("strtab_base", e.str_off, d[163:132]);
		match("strtab_len", e.str_size, d[195:164]);
		match("artifact_length", e.length, d[227:196]);
	endfunction

	function int pending();
		return summaries_due.size();
	endfunction
endclass

module route_table_header_validator_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 100;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // [7:0] data_byte
	logic s_tlast;                   // last_byte
	logic m_tvalid;
	logic m_tready;
	// [3:0] status, [67:4] checksum, [99:68] routes, [131:100] route_base,
	// [163:132] strtab_base, [195:164] strtab_len, [227:196] length
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	artifact_tracker sb;
	logic [7:0] art [$];
	int  bytes_sent;
	bit  hold_req;
	bit  calm;

	route_table_header_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** route_table_header_validator: FAILED **");
		$finish;
	end

	// receiver: short random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		m_tready = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (hold_req) begin
					stall_left = LONG_HOLD;
					hold_req = 0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 4);
				end
			end else begin
				stall_left--;
			end
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_summary(m_tdata);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic load_setup(input logic [31:0] cnt, input logic [31:0] ver,
			input logic [31:0] mark, input logic [31:0] hdr, input logic [31:0] ent);
		write_reg(CFG_ROUTE_COUNT, cnt);
		write_reg(CFG_VERSION, ver);
		write_reg(CFG_ENDIAN, mark);
		write_reg(CFG_HEADER_BYTES, hdr);
		write_reg(CFG_ENTRY_BYTES, ent);
	endtask

	task automatic pick_setup();
		logic [31:0] cnt, ver, mark, hdr, ent;
		int r;
		r = $urandom_range(0, 99);
		cnt = (r < 85) ? $urandom_range(0, 3) : (r < 93) ? 32'hFFFFFFFF : $urandom;
		r = $urandom_range(0, 99);
		ver = (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFFFFFF : $urandom;
		r = $urandom_range(0, 99);
		mark = (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFFFFFF : $urandom;
		r = $urandom_range(0, 99);
		hdr = (r < 75) ? $urandom_range(48, 64) : (r < 90) ? $urandom_range(1, 47) :
			(r < 95) ? 32'd48 : 32'hFFFFFFFF;
		r = $urandom_range(0, 99);
		ent = (r < 70) ? $urandom_range(32, 40) : (r < 80) ? 32'd65535 :
			(r < 90) ? 32'd32 : $urandom_range(32, 65535);
		ent[31:16] = 16'($urandom); // upper bits must be dropped
		load_setup(cnt, ver, mark, hdr, ent);
	endtask

	// Lay out a consistent artifact for the current settings, then damage it as asked.
	// sel picks the damaged word (10, 11 are the stored checksum) or sizes a noise run.
	task automatic build_artifact(input art_kind_t kind, input int sel);
		logic [31:0] w [WORD_COUNT];
		logic [31:0] hlen, prod;
		logic [63:0] h;
		int n, i, idx;
		art.delete();
		if (kind == ART_NOISE) begin
			n = $urandom_range(1, 4 + sel * 5);
			for (i = 0; i < n; i++)
				art.push_back(8'($urandom_range(0, 255)));
			return;
		end
		prod = sb.want_routes * {16'd0, sb.entry_size};
		hlen = (sb.want_hdr >= 48 && sb.want_hdr <= 96) ? sb.want_hdr : 32'd48;
		w[0] = TAG_WORD;
		w[1] = sb.want_version;
		w[2] = sb.want_marker;
		w[3] = sb.want_hdr;
		w[4] = sb.want_routes;
		w[5] = sb.want_routes;
		w[6] = hlen + $urandom_range(0, 3);
		w[7] = prod;
		// an oversized route table cannot be laid out; unless an earlier check fails, it ends in a range error
		w[8] = (prod <= 160) ? w[6] + prod + $urandom_range(0, 3) : hlen + $urandom_range(0, 8);
		w[9] = $urandom_range(0, 8);
		n = w[8] + w[9] + $urandom_range(0, 3);
		if (kind == ART_OVERLAP)
			w[8] = w[6] + w[7] - 1;
		if (kind == ART_BAD_WORD && sel < WORD_COUNT)
			w[sel] = w[sel] ^ (32'd1 << $urandom_range(0, 31));
		for (i = 0; i < n; i++)
			art.push_back((i < SUM_START) ? w[i / 4][8 * (i % 4) +: 8] :
				8'($urandom_range(0, 255)));
		h = HASH_SEED;
		for (i = 0; i < n; i++)
			h = fnv1a_mix(h, (i >= SUM_START && i < SUM_END) ? 8'h00 : art[i]);
		for (i = 0; i < 8; i++)
			art[SUM_START + i] = h[8 * i +: 8];
		if (kind == ART_BAD_WORD && sel >= WORD_COUNT) begin
			idx = SUM_START + (sel - WORD_COUNT) * 4 + $urandom_range(0, 3);
			art[idx] = art[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (kind == ART_BAD_BYTE) begin
			idx = $urandom_range(0, n - 1);
			art[idx] = art[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (kind == ART_TRUNC) begin
			n = $urandom_range(1, n - 1);
			while (art.size() > n)
				void'(art.pop_back());
		end
	endtask

	task automatic send_artifact(input bit rush);
		for (int i = 0; i < art.size(); i++) begin
			if (!calm && !rush && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= art[i];
			s_tlast <= (i == art.size() - 1);
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			sb.take_byte(art[i], i == art.size() - 1);
			bytes_sent++;
		end
	endtask

	task automatic run_one(input art_kind_t kind, input int sel);
		build_artifact(kind, sel);
		send_artifact(0);
	endtask

	// idle the input, let every summary come back, then wait out the pipeline
	task automatic settle();
		s_tvalid <= 0;
		s_tlast <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic art_kind_t random_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return ART_GOOD;
		if (r < 65) return ART_BAD_WORD;
		if (r < 72) return ART_OVERLAP;
		if (r < 80) return ART_BAD_BYTE;
		if (r < 90) return ART_TRUNC;
		return ART_NOISE;
	endfunction

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		bytes_sent = 0;
		hold_req = 0;
		calm = 0;
		sb = new;
		sb.restart();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// register defaults: one artifact per check outcome
		run_one(ART_GOOD, 0);
		run_one(ART_BAD_WORD, 0);
		run_one(ART_BAD_WORD, 1);
		run_one(ART_BAD_WORD, 2);
		run_one(ART_BAD_WORD, 5);
		run_one(ART_BAD_WORD, 9);
		run_one(ART_BAD_WORD, 10);
		run_one(ART_OVERLAP, 0);
		run_one(ART_TRUNC, 0);
		run_one(ART_NOISE, 0);
		settle();

		// unknown index must leave the registers alone
		write_reg(CFG_SPARE_IDX, $urandom);
		run_one(ART_GOOD, 0);
		settle();

		// all registers at their top values: everything reads as truncated
		load_setup(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		run_one(ART_GOOD, 0);
		settle();

		// bottom values, junk above the entry size field
		load_setup(32'd0, 32'd0, 32'd0, 32'd48, 32'hABCD0020);
		run_one(ART_GOOD, 0);
		settle();

		// short header: missing header bytes read as zero
		load_setup(32'd0, 32'd1, 32'd0, 32'd8, 32'd32);
		run_one(ART_TRUNC, 0);
		art = '{8'h53, 8'h4C, 8'h52};
		send_artifact(0);
		settle();

		// receiver holds off while runts pile up behind it
		pick_setup();
		hold_req = 1;
		repeat (10) begin
			build_artifact(ART_NOISE, 0);
			send_artifact(1);
		end
		settle();

		calm = 1;
		pick_setup();
		do
			run_one(random_kind(), $urandom_range(0, 11));
		while (bytes_sent < 600);
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** route_table_header_validator: PASSED **");
		else
			$display("** route_table_header_validator: FAILED **");
		$finish;
	end

endmodule
